// ----- hdl/fetc_pkg.sv -----
`default_nettype none

package fetc_pkg;

  localparam int TABLE_BYTES = 65536;
  localparam int TB_AW       = $clog2(TABLE_BYTES);
  localparam int LANES       = 4;
  localparam int BANK_ROWS   = (TABLE_BYTES + LANES - 1) / LANES;
  localparam int ROW_AW      = TB_AW - 2;
  // Wide enough for four times the largest cluster number plus three, and for TABLE_BYTES.
  localparam int CALC_W      = (TB_AW + 1 > 18) ? TB_AW + 1 : 18;

  localparam logic [1:0] MODE_FAT12 = 2'd0;
  localparam logic [1:0] MODE_FAT16 = 2'd1;
  localparam logic [1:0] MODE_FAT32 = 2'd2;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_FETCH = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] index;
    logic [27:0] value;
  } in_item_t;

  typedef struct packed {
    logic [27:0] result_value;
    logic        range_error;
  } out_item_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [1:0]       mode;
    logic             odd;
    logic             err;
    logic [TB_AW-1:0] base;
    logic [27:0]      value;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

// ----- hdl/fat_entry_table_codec_top.sv -----
`default_nettype none

// FAT table entry codec. The block holds a FAT of TABLE_BYTES bytes in four
// byte-lane memories and reads or writes one cluster's next-cluster entry in
// FAT12, FAT16 or FAT32 packing, selected by the cfg_wdata mode register
// (mode three behaves as FAT12). Raw load and fetch commands fill and dump the
// table byte by byte; table contents are undefined until written. Every
// accepted input transfer yields exactly one output transfer, in order: the
// entry or byte read, or zero for writes and loads, with range_error set and
// the table untouched when an addressed byte lies past the table. An in-range
// item passes through two back-end states, one to read the four-byte window and
// one to merge and write it back; out-of-range items skip the read. One item
// is done before the next starts. A two-entry queue after the address decode
// lets the input keep accepting while a result waits on out_ready.
// Change the mode only while no transfer is outstanding.
module fat_entry_table_codec_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fetc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fetc_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_wdata
);

  fetc_pkg::desc_t     front_desc;
  fetc_pkg::desc_t     head;
  fetc_pkg::q_status_t q_status;
  logic                push;
  logic                pop;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  fetc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (in_data),
    .desc      (front_desc)
  );

  fetc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (front_desc),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  fetc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hdl/fetc_front.sv -----
`default_nettype none

module fetc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  input  wire fetc_pkg::in_item_t item,
  output fetc_pkg::desc_t         desc
);

  logic [1:0]                  fat_mode_r;
  logic [1:0]                  mode;
  logic [fetc_pkg::CALC_W-1:0] idx_c;
  logic [fetc_pkg::CALC_W-1:0] half_c;
  logic [fetc_pkg::CALC_W-1:0] base;
  logic [fetc_pkg::CALC_W-1:0] last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_mode_r <= fetc_pkg::MODE_FAT12;
    end else if (cfg_we) begin
      fat_mode_r <= cfg_wdata;
    end
  end

  // Mode three packs like FAT12.
  assign mode = (fat_mode_r == fetc_pkg::MODE_FAT16 || fat_mode_r == fetc_pkg::MODE_FAT32)
              ? fat_mode_r : fetc_pkg::MODE_FAT12;

  assign idx_c  = fetc_pkg::CALC_W'(item.index);
  assign half_c = fetc_pkg::CALC_W'(item.index[15:1]);

  always_comb begin
    if (item.cmd == fetc_pkg::CMD_LOAD || item.cmd == fetc_pkg::CMD_FETCH) begin
      base = idx_c;
      last = idx_c;
    end else if (mode == fetc_pkg::MODE_FAT32) begin
      base = idx_c << 2;
      last = (idx_c << 2) + fetc_pkg::CALC_W'(3);
    end else if (mode == fetc_pkg::MODE_FAT16) begin
      base = idx_c << 1;
      last = (idx_c << 1) + fetc_pkg::CALC_W'(1);
    end else begin
      base = half_c + (half_c << 1);
      last = half_c + (half_c << 1) + (item.index[0] ? fetc_pkg::CALC_W'(2)
                                                      : fetc_pkg::CALC_W'(1));
    end
  end

  always_comb begin
    desc.cmd   = item.cmd;
    desc.mode  = mode;
    desc.odd   = item.index[0];
    desc.err   = (last >= fetc_pkg::CALC_W'(fetc_pkg::TABLE_BYTES));
    desc.base  = base[fetc_pkg::TB_AW-1:0];
    desc.value = item.value;
  end

endmodule

`default_nettype wire

// ----- hdl/fetc_queue.sv -----
`default_nettype none

module fetc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire fetc_pkg::desc_t push_desc,
  input  wire logic            pop,
  output fetc_pkg::desc_t      head,
  output fetc_pkg::q_status_t  status
);

  fetc_pkg::desc_t slot_r [2];
  logic            wptr_r;
  logic            rptr_r;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_desc;
    end
  end

  assign head         = slot_r[rptr_r];
  assign status.empty = (cnt_r == 2'd0);
  assign status.full  = (cnt_r == 2'd2);

endmodule

`default_nettype wire

// ----- hdl/fetc_back.sv -----
`default_nettype none

module fetc_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fetc_pkg::desc_t     head,
  input  wire fetc_pkg::q_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fetc_pkg::out_item_t      out_data
);

  typedef enum logic [1:0] {
    S_ISSUE  = 2'b01,
    S_FINISH = 2'b10
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  fetc_pkg::out_item_t       out_data_r;
  fetc_pkg::out_item_t       out_data_nxt;
  logic                      slot_free;
  logic                      rd_en;
  logic                      wr_en;
  logic [7:0]                lane_rdata [fetc_pkg::LANES];
  logic [7:0]                lane_wdata [fetc_pkg::LANES];
  logic                      lane_we    [fetc_pkg::LANES];
  logic [fetc_pkg::ROW_AW-1:0] lane_row [fetc_pkg::LANES];
  logic [7:0]                b          [fetc_pkg::LANES];
  logic [7:0]                nb         [fetc_pkg::LANES];
  logic                      wb         [fetc_pkg::LANES];
  logic [27:0]               res;

  assign slot_free = !out_valid_r || out_ready;

  // Four byte lanes, one per value of the low two address bits, so any
  // four-byte window touches each lane at most once.
  for (genvar l = 0; l < fetc_pkg::LANES; l++) begin : g_lane
    logic [7:0]             mem [fetc_pkg::BANK_ROWS];
    logic [1:0]             k;
    logic [fetc_pkg::TB_AW-1:0] addr;

    assign k           = 2'(2'(l) - head.base[1:0]);
    assign addr        = head.base + fetc_pkg::TB_AW'(k);
    assign lane_row[l] = addr[fetc_pkg::TB_AW-1:2];
    assign lane_wdata[l] = nb[k];
    assign lane_we[l]    = wb[k] && wr_en;

    always_ff @(posedge clk) begin
      if (lane_we[l]) begin
        mem[lane_row[l]] <= lane_wdata[l];
      end
      if (rd_en) begin
        lane_rdata[l] <= mem[lane_row[l]];
      end
    end
  end

  // Window bytes in address order, then the merged bytes to write back.
  always_comb begin
    for (int k = 0; k < fetc_pkg::LANES; k++) begin
      b[k]  = lane_rdata[2'(head.base[1:0] + 2'(k))];
      nb[k] = 8'd0;
      wb[k] = 1'b0;
    end
    res = 28'd0;
    case (head.cmd)
      fetc_pkg::CMD_LOAD: begin
        nb[0] = head.value[7:0];
        wb[0] = 1'b1;
      end
      fetc_pkg::CMD_FETCH: begin
        res = {20'd0, b[0]};
      end
      fetc_pkg::CMD_READ: begin
        if (head.mode == fetc_pkg::MODE_FAT32) begin
          res = {b[3][3:0], b[2], b[1], b[0]};
        end else if (head.mode == fetc_pkg::MODE_FAT16) begin
          res = {12'd0, b[1], b[0]};
        end else if (head.odd) begin
          res = {16'd0, b[2], b[1][7:4]};
        end else begin
          res = {16'd0, b[1][3:0], b[0]};
        end
      end
      fetc_pkg::CMD_WRITE: begin
        if (head.mode == fetc_pkg::MODE_FAT32) begin
          nb[0] = head.value[7:0];
          nb[1] = head.value[15:8];
          nb[2] = head.value[23:16];
          nb[3] = {b[3][7:4], head.value[27:24]};
          wb[0] = 1'b1;
          wb[1] = 1'b1;
          wb[2] = 1'b1;
          wb[3] = 1'b1;
        end else if (head.mode == fetc_pkg::MODE_FAT16) begin
          nb[0] = head.value[7:0];
          nb[1] = head.value[15:8];
          wb[0] = 1'b1;
          wb[1] = 1'b1;
        end else if (head.odd) begin
          nb[1] = {head.value[3:0], b[1][3:0]};
          nb[2] = head.value[11:4];
          wb[1] = 1'b1;
          wb[2] = 1'b1;
        end else begin
          nb[0] = head.value[7:0];
          nb[1] = {b[1][7:4], head.value[11:8]};
          wb[0] = 1'b1;
          wb[1] = 1'b1;
        end
      end
      default: begin
        res = 28'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    case (state_r)
      S_ISSUE: begin
        if (!q_status.empty) begin
          if (head.err) begin
            // Out-of-range items skip the table entirely.
            if (slot_free) begin
              pop                       = 1'b1;
              out_valid_nxt             = 1'b1;
              out_data_nxt.result_value = 28'd0;
              out_data_nxt.range_error  = 1'b1;
            end
          end else begin
            rd_en     = 1'b1;
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          wr_en                     = 1'b1;
          pop                       = 1'b1;
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_value = res;
          out_data_nxt.range_error  = 1'b0;
          state_nxt                 = S_ISSUE;
        end
      end
      default: begin
        state_nxt = S_ISSUE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ISSUE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- tb/fat_entry_table_codec_checker.sv -----
module fat_entry_table_codec_checker
  import fetc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  output int         fail_count,
  output int         results_owed
);

  logic [7:0] fat_image [TABLE_BYTES];
  logic [1:0] entry_mode = MODE_FAT12;
  out_item_t  pending_results [$];
  int         mismatches = 0;
  int         result_no = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, result_no, what);
  endtask

  // Applies one command to the shadow table and returns the result it should give.
  function automatic out_item_t table_access(input in_item_t it);
    int        base;
    int        last;
    out_item_t r;
    r = '0;
    if (it.cmd == CMD_LOAD || it.cmd == CMD_FETCH) begin
      base = it.index;
      last = base;
    end else if (entry_mode == MODE_FAT32) begin
      base = 4 * it.index;
      last = base + 3;
    end else if (entry_mode == MODE_FAT16) begin
      base = 2 * it.index;
      last = base + 1;
    end else begin
      base = 3 * (it.index >> 1);
      last = base + (it.index[0] ? 2 : 1);
    end
    if (last >= TABLE_BYTES) begin
      r.range_error = 1'b1;
      return r;
    end
    case (it.cmd)
      CMD_LOAD: fat_image[base] = it.value[7:0];
      CMD_FETCH: r.result_value = {20'd0, fat_image[base]};
      CMD_READ: begin
        if (entry_mode == MODE_FAT32)
          r.result_value = {fat_image[base+3][3:0], fat_image[base+2], fat_image[base+1],
                            fat_image[base]};
        else if (entry_mode == MODE_FAT16)
          r.result_value = {12'd0, fat_image[base+1], fat_image[base]};
        else if (it.index[0])
          r.result_value = {16'd0, fat_image[base+2], fat_image[base+1][7:4]};
        else
          r.result_value = {16'd0, fat_image[base+1][3:0], fat_image[base]};
      end
      CMD_WRITE: begin
        if (entry_mode == MODE_FAT32) begin
          fat_image[base]   = it.value[7:0];
          fat_image[base+1] = it.value[15:8];
          fat_image[base+2] = it.value[23:16];
          fat_image[base+3] = {fat_image[base+3][7:4], it.value[27:24]};
        end else if (entry_mode == MODE_FAT16) begin
          fat_image[base]   = it.value[7:0];
          fat_image[base+1] = it.value[15:8];
        end else if (it.index[0]) begin
          // The odd entry owns the high nibble of the shared middle byte.
          fat_image[base+1] = {it.value[3:0], fat_image[base+1][3:0]};
          fat_image[base+2] = it.value[11:4];
        end else begin
          fat_image[base]   = it.value[7:0];
          fat_image[base+1] = {fat_image[base+1][7:4], it.value[11:8]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      entry_mode = MODE_FAT12;
      pending_results.delete();
    end else begin
      // A result leaving at this edge always belongs to an earlier transfer.
      if (out_valid && out_ready) begin
        result_no++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transfer outstanding");
        end else begin
          want = pending_results.pop_front();
          if (out_data.result_value !== want.result_value)
            report_mismatch($sformatf("result_value %h, expected %h",
                                      out_data.result_value, want.result_value));
          if (out_data.range_error !== want.range_error)
            report_mismatch($sformatf("range_error %b, expected %b",
                                      out_data.range_error, want.range_error));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(table_access(in_data));
      if (cfg_we)
        entry_mode = cfg_wdata;
    end
    fail_count   <= mismatches;
    results_owed <= pending_results.size();
  end

endmodule

// ----- tb/tb_fat_entry_table_codec_top.sv -----
module tb_fat_entry_table_codec_top;
  import fetc_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // decodes as FAT12
  localparam int         PHASES     = 7;
  localparam int         PHASE_ITEMS = 75;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_wdata;

  int         fail_count;
  int         results_owed;
  int         stall_pct = 0;
  logic [1:0] cur_mode = MODE_FAT12;
  bit         byte_set [TABLE_BYTES];

  logic [1:0] phase_mode [PHASES] = '{MODE_FAT12, MODE_FAT16, MODE_FAT32, MODE_SPARE,
                                      MODE_FAT32, MODE_FAT12, MODE_FAT16};
  int         phase_stall [PHASES] = '{25, 0, 30, 15, 40, 20, 0};

  fat_entry_table_codec_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fat_entry_table_codec_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("** fat_entry_table_codec_top: FAILED **");
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        hold = $urandom_range(1, 5);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t mk(input cmd_t c, input int idx, input logic [27:0] v);
    in_item_t it;
    it.cmd   = c;
    it.index = 16'(idx);
    it.value = v;
    return it;
  endfunction

  function automatic logic [27:0] rand_value();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 28'hFFF_FFFF;
      default: return 28'($urandom());
    endcase
  endfunction

  // First cluster number whose bytes run past the table in the current packing.
  function automatic int entry_limit();
    if (cur_mode == MODE_FAT32) return TABLE_BYTES / 4;
    if (cur_mode == MODE_FAT16) return TABLE_BYTES / 2;
    return (TABLE_BYTES / 3) * 2;
  endfunction

  // Bytes a command touches; returns 0 when they fall outside the table.
  function automatic bit span_of(input in_item_t it, output int lo, output int hi);
    int base;
    if (it.cmd == CMD_LOAD || it.cmd == CMD_FETCH) begin
      lo = it.index;
      hi = lo;
    end else if (cur_mode == MODE_FAT32) begin
      lo = 4 * it.index;
      hi = lo + 3;
    end else if (cur_mode == MODE_FAT16) begin
      lo = 2 * it.index;
      hi = lo + 1;
    end else begin
      base = 3 * (it.index >> 1);
      lo = it.index[0] ? base + 1 : base;
      hi = it.index[0] ? base + 2 : base + 1;
    end
    return hi < TABLE_BYTES;
  endfunction

  function automatic logic [15:0] pick_index(input cmd_t c);
    int roll;
    bit raw;
    roll = $urandom_range(0, 99);
    raw  = (c == CMD_LOAD || c == CMD_FETCH);
    if (roll < 70)
      return raw ? 16'($urandom_range(0, 255)) : 16'($urandom_range(0, 63));
    if (roll < 85)
      return raw ? 16'(TABLE_BYTES - 1 - $urandom_range(0, 7))
                 : 16'(entry_limit() - 3 + $urandom_range(0, 5));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic push_item(input in_item_t it);
    if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Loads any byte the command would read before it was ever written, then sends it.
  task automatic issue(input in_item_t it);
    int       lo;
    int       hi;
    int       rlo;
    int       rhi;
    bit       fits;
    in_item_t fill;
    fits = span_of(it, lo, hi);
    rlo  = lo;
    rhi  = lo - 1;
    if (fits) begin
      case (it.cmd)
        CMD_READ:  rhi = hi;
        CMD_FETCH: rhi = lo;
        CMD_WRITE: begin
          if (cur_mode == MODE_FAT32) begin
            rlo = hi;
            rhi = hi;
          end else if (cur_mode != MODE_FAT16) begin
            // The byte shared by an even and an odd entry is read back.
            rlo = it.index[0] ? lo : hi;
            rhi = rlo;
          end
        end
        default: ;
      endcase
    end
    for (int a = rlo; a <= rhi; a++) begin
      if (!byte_set[a]) begin
        fill = mk(CMD_LOAD, a, rand_value());
        byte_set[a] = 1'b1;
        push_item(fill);
      end
    end
    if (fits && (it.cmd == CMD_LOAD || it.cmd == CMD_WRITE))
      for (int a = lo; a <= hi; a++) byte_set[a] = 1'b1;
    push_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic set_mode(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    cur_mode   = m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic boundary_items();
    int top;
    top = entry_limit();
    issue(mk(CMD_WRITE, top - 1, 28'hFFF_FFFF));
    issue(mk(CMD_READ, top - 1, '0));
    issue(mk(CMD_READ, top, '0));
    issue(mk(CMD_WRITE, top, 28'hFFF_FFFF));
    issue(mk(CMD_READ, 16'hFFFF, '0));
    // The fourth byte keeps its high nibble under a FAT32 write.
    issue(mk(CMD_LOAD, 3, 28'h00000A5));
    issue(mk(CMD_WRITE, 0, 28'h1234567));
    issue(mk(CMD_FETCH, 3, '0));
    issue(mk(CMD_READ, 0, '0));
  endtask

  task automatic random_items(input int count);
    in_item_t it;
    int       roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)      it.cmd = CMD_READ;
      else if (roll < 70) it.cmd = CMD_WRITE;
      else if (roll < 85) it.cmd = CMD_LOAD;
      else                it.cmd = CMD_FETCH;
      it.index = pick_index(it.cmd);
      it.value = rand_value();
      issue(it);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = MODE_FAT12;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(MODE_FAT12);
    stall_pct = phase_stall[0];
    issue(mk(CMD_LOAD, 0, 28'hFFF_FFFF));
    issue(mk(CMD_FETCH, 0, '0));
    issue(mk(CMD_LOAD, TABLE_BYTES - 1, 28'hFFF_FF00));
    issue(mk(CMD_FETCH, TABLE_BYTES - 1, '0));
    issue(mk(CMD_WRITE, 0, 28'hFFF_FABC));
    issue(mk(CMD_WRITE, 1, 28'h0000123));
    issue(mk(CMD_READ, 0, '0));
    issue(mk(CMD_READ, 1, '0));
    // Nibble writes must clear the old nibble and leave the neighbor alone.
    issue(mk(CMD_WRITE, 1, 28'h0000FFF));
    issue(mk(CMD_WRITE, 1, '0));
    issue(mk(CMD_READ, 0, '0));
    issue(mk(CMD_READ, 1, '0));
    issue(mk(CMD_WRITE, 0, 28'h0000FFF));
    issue(mk(CMD_WRITE, 0, '0));
    issue(mk(CMD_READ, 1, '0));
    issue(mk(CMD_READ, entry_limit() - 2, '0));

    for (int p = 0; p < PHASES; p++) begin
      // Mode changes only once every result is back.
      drain();
      if (p != 0)
        set_mode(phase_mode[p]);
      stall_pct = phase_stall[p];
      boundary_items();
      random_items(PHASE_ITEMS);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** fat_entry_table_codec_top: PASSED **");
    end else begin
      $display("** fat_entry_table_codec_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- fat_entry_table_codec_top.f -----
hdl/fetc_pkg.sv
hdl/fetc_front.sv
hdl/fetc_queue.sv
hdl/fetc_back.sv
hdl/fat_entry_table_codec_top.sv
tb/fat_entry_table_codec_checker.sv
tb/tb_fat_entry_table_codec_top.sv
